/* rtl/nnl_pkg.sv */
// Shared types and codes for the nearest-neighbor list builder.
// No dependencies.
package nnl_pkg;

  // input item kinds (tuser)
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_CITY_COUNT     = 1'b0;
  localparam logic CFG_NEIGHBOR_COUNT = 1'b1;

  localparam int CITY_COUNT_W     = 13;
  localparam int NEIGHBOR_COUNT_W = 6;
  localparam int INDEX_W          = 12;
  localparam int IN_COORD_W       = 24;
  localparam int DIST_OUT_W       = 25;

  localparam logic [CITY_COUNT_W-1:0]     CITY_COUNT_RST     = 13'd4096;
  localparam logic [NEIGHBOR_COUNT_W-1:0] NEIGHBOR_COUNT_RST = 6'd50;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_QRD  = 14'b00000000000010,
    S_QLAT = 14'b00000000000100,
    S_DRD  = 14'b00000000001000,
    S_DSUB = 14'b00000000010000,
    S_MULX = 14'b00000000100000,
    S_MULY = 14'b00000001000000,
    S_ADD  = 14'b00000010000000,
    S_SQST = 14'b00000100000000,
    S_SQW  = 14'b00001000000000,
    S_SEL  = 14'b00010000000000,
    S_SELE = 14'b00100000000000,
    S_MARK = 14'b01000000000000,
    S_EMIT = 14'b10000000000000
  } state_t;

endpackage

/* rtl/nearest_neighbor_list_builder_core.sv */
// Nearest-neighbor list builder: coordinate store, per-query distance pass and
// repeated selection passes. Depends on nnl_pkg and nnl_sqrt.
//
// Usage:
//  in_*  channel: tuser = action (0 load, 1 query). tdata = city_index, x, y.
//        A load writes one city's coordinates and gives no result item.
//  out_* channel: tdata = neighbor_index, distance; tlast marks the last item
//        of a query's run; tuser flags a bad query (index not below city count).
//  cfg_*: plain write port, index 0 = city_count, 1 = neighbor_count; write
//        only while the block is idle.
//  Timing: the distance pass is bound by the bit-serial square root, the
//        selection passes by the single read port of the distance store
//        (one city per cycle, one pass per neighbor).
//  in_tready is high only while no query is in progress.
//  Reset: control state cleared, registers to 4096 / 50; the coordinate and
//        distance stores are not cleared (taken marks live in the distance
//        store and are rewritten by every in-range query's distance pass).
//  A stalled receiver holds the current result in the output register; the
//        next selection pass may run but waits to present its result.
module nearest_neighbor_list_builder_core #(
  parameter int MAX_CITIES = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [11:0] city_index, [35:12] x_coord, [59:36] y_coord
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] neighbor_index, [36:12] distance
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] bad_query
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [nnl_pkg::CITY_COUNT_W-1:0] cfg_wdata
);
  import nnl_pkg::*;

  localparam int AW    = $clog2(MAX_CITIES);
  localparam int CNT_W = $clog2(MAX_CITIES + 1);
  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;        // rounded distance width
  localparam int PW    = 2 * CW;        // one square
  localparam int SUMW  = 2 * DW;        // radicand width

  state_t state_r;

  logic [CITY_COUNT_W-1:0]     city_count_r;
  logic [NEIGHBOR_COUNT_W-1:0] neighbor_count_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r     <= CITY_COUNT_RST;
      neighbor_count_r <= NEIGHBOR_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CITY_COUNT:     city_count_r     <= cfg_wdata;
        CFG_NEIGHBOR_COUNT: neighbor_count_r <= NEIGHBOR_COUNT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // effective count, clamped to the store depth
  logic [CNT_W-1:0] n_eff, n_last;
  assign n_eff  = (32'(city_count_r) > 32'(MAX_CITIES)) ? CNT_W'(MAX_CITIES)
                                                         : CNT_W'(city_count_r);
  assign n_last = n_eff - 1'b1;

  // input fields
  logic [INDEX_W-1:0]    in_idx;
  logic [IN_COORD_W-1:0] in_x, in_y;
  logic                  in_acc;
  assign in_idx = in_tdata[11:0];
  assign in_x   = in_tdata[35:12];
  assign in_y   = in_tdata[59:36];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // coordinate store
  logic [CW-1:0] x_mem [MAX_CITIES];
  logic [CW-1:0] y_mem [MAX_CITIES];
  logic [CW-1:0] crd_x_r, crd_y_r;
  logic [AW-1:0] crd_addr, q_addr_r;
  logic          ld_we;
  logic [CNT_W-1:0] j_r;

  assign ld_we    = in_acc && (in_tuser[0] == ACT_LOAD) && (32'(in_idx) < 32'(MAX_CITIES));
  assign crd_addr = (state_r == S_QRD) ? q_addr_r : j_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (ld_we) begin
      x_mem[AW'(in_idx)] <= CW'(in_x);
      y_mem[AW'(in_idx)] <= CW'(in_y);
    end
    crd_x_r <= x_mem[crd_addr];
    crd_y_r <= y_mem[crd_addr];
  end

  // distance store: bit DW is the taken mark
  logic [DW:0]   d_mem [MAX_CITIES];
  logic [DW:0]   d_rd_r, d_wdata;
  logic [AW-1:0] d_waddr;
  logic          d_we;
  logic [CNT_W-1:0] sj_r;

  always_ff @(posedge clk) begin
    if (d_we) d_mem[d_waddr] <= d_wdata;
    d_rd_r <= d_mem[sj_r[AW-1:0]];
  end

  // shared arithmetic
  logic [CW-1:0]   qx_r, qy_r, dx_r, dy_r, mul_in;
  logic [PW-1:0]   prod_r;
  logic [SUMW-1:0] acc_r;
  logic            sq_start, sq_done;
  logic [DW-1:0]   sq_root;

  assign mul_in   = (state_r == S_MULX) ? dx_r : dy_r;
  assign sq_start = (state_r == S_SQST);

  nnl_sqrt #(.RW(DW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (acc_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    case (state_r)
      S_QLAT: begin
        qx_r <= crd_x_r;
        qy_r <= crd_y_r;
      end
      S_DSUB: begin
        dx_r <= (crd_x_r >= qx_r) ? crd_x_r - qx_r : qx_r - crd_x_r;
        dy_r <= (crd_y_r >= qy_r) ? crd_y_r - qy_r : qy_r - crd_y_r;
      end
      S_MULX: prod_r <= mul_in * mul_in;
      S_MULY: begin
        acc_r  <= SUMW'(prod_r);
        prod_r <= mul_in * mul_in;
      end
      S_ADD:  acc_r <= acc_r + SUMW'(prod_r);
      default: ;
    endcase
  end

  // selection scan
  logic          pipe_v_r, found_r;
  logic [AW-1:0] pipe_j_r, best_i_r;
  logic [DW-1:0] best_d_r;
  logic          take;
  assign take = pipe_v_r && !d_rd_r[DW] && (!found_r || d_rd_r[DW-1:0] <= best_d_r);

  // result staging and output register
  logic [NEIGHBOR_COUNT_W-1:0] want_r, rank_r;
  logic [AW-1:0]   res_idx_r;
  logic [DW-1:0]   res_dist_r;
  logic [INDEX_W-1:0] bad_idx_r;
  logic            res_last_r, res_bad_r;
  logic            out_tvalid_r, out_tlast_r, out_bad_r;
  logic [INDEX_W-1:0]    out_idx_r;
  logic [DIST_OUT_W-1:0] out_dist_r;
  logic            emit_go;

  assign emit_go = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  always_comb begin
    d_we    = 1'b0;
    d_waddr = j_r[AW-1:0];
    d_wdata = {j_r[AW-1:0] == q_addr_r, sq_root};
    if (state_r == S_SQW && sq_done) begin
      d_we = 1'b1;
    end else if (state_r == S_MARK) begin
      d_we    = 1'b1;
      d_waddr = best_i_r;
      d_wdata = {1'b1, best_d_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      pipe_v_r     <= 1'b0;
      found_r      <= 1'b0;
      j_r          <= '0;
      sj_r         <= '0;
      rank_r       <= '0;
      want_r       <= '0;
    end else begin
      pipe_v_r <= (state_r == S_SEL);
      if (emit_go)         out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      if (take) found_r <= 1'b1;

      case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser[0] == ACT_QUERY) begin
            q_addr_r  <= AW'(in_idx);
            bad_idx_r <= in_idx;
            want_r    <= (32'(neighbor_count_r) > 32'(n_last)) ? NEIGHBOR_COUNT_W'(n_last)
                                                               : neighbor_count_r;
            if (32'(in_idx) >= 32'(n_eff)) begin
              res_bad_r  <= 1'b1;
              res_last_r <= 1'b1;
              res_dist_r <= '0;
              state_r    <= S_EMIT;
            end else begin
              state_r <= S_QRD;
            end
          end
        end
        S_QRD:  state_r <= S_QLAT;
        S_QLAT: begin
          j_r     <= '0;
          state_r <= S_DRD;
        end
        S_DRD:  state_r <= S_DSUB;
        S_DSUB: state_r <= S_MULX;
        S_MULX: state_r <= S_MULY;
        S_MULY: state_r <= S_ADD;
        S_ADD:  state_r <= S_SQST;
        S_SQST: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            if (j_r == n_last) begin
              // self first, at distance zero
              res_idx_r  <= q_addr_r;
              res_dist_r <= '0;
              res_bad_r  <= 1'b0;
              res_last_r <= (want_r == '0);
              rank_r     <= NEIGHBOR_COUNT_W'(1);
              state_r    <= S_EMIT;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_DRD;
            end
          end
        end
        S_SEL: begin
          pipe_j_r <= sj_r[AW-1:0];
          if (sj_r == n_last) state_r <= S_SELE;
          else                sj_r    <= sj_r + 1'b1;
        end
        S_SELE: state_r <= S_MARK;
        S_MARK: begin
          res_idx_r  <= best_i_r;
          res_dist_r <= best_d_r;
          res_bad_r  <= 1'b0;
          res_last_r <= (rank_r == want_r);
          rank_r     <= rank_r + 1'b1;
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_idx_r    <= res_bad_r ? bad_idx_r : INDEX_W'(res_idx_r);
            out_dist_r   <= DIST_OUT_W'(res_dist_r);
            out_tlast_r  <= res_last_r;
            out_bad_r    <= res_bad_r;
            sj_r         <= '0;
            found_r      <= 1'b0;
            state_r      <= res_last_r ? S_IDLE : S_SEL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_i_r <= pipe_j_r;
      best_d_r <= d_rd_r[DW-1:0];
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {3'b000, out_dist_r, out_idx_r};
  assign out_tlast    = out_tlast_r;
  assign out_tuser[0] = out_bad_r;

  // checks
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("bad query result not marked last");

  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_SQW)
    else $error("square root finished outside its wait state");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK |-> rank_r <= want_r && rank_r != '0)
    else $error("rank past requested neighbor count");

  a_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK |-> found_r)
    else $error("selection pass found no free city");

  a_emit_self: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQW && sq_done && j_r == n_last |=> state_r == S_EMIT && res_dist_r == '0)
    else $error("self result not staged after distance pass");

endmodule

/* rtl/nnl_sqrt.sv */
// Iterative integer square root with round-to-nearest, one result bit per cycle.
// No package dependencies.
module nnl_sqrt #(
  parameter int RW = 25
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] rad,
  output logic            done,
  output logic [RW-1:0]   root
);
  localparam int SW   = 2 * RW;
  localparam int CNTW = $clog2(RW + 1);

  logic            busy_r, done_r;
  logic [CNTW-1:0] cnt_r;
  logic [SW-1:0]   s_r, r_r, bit_r;
  logic [SW-1:0]   trial;
  logic            ge;

  assign trial = r_r + bit_r;
  assign ge    = (s_r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r   <= rad;
      r_r   <= '0;
      bit_r <= SW'(1) << (SW - 2);
    end else if (busy_r) begin
      if (ge) begin
        s_r <= s_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // remainder above root means the true root is past the half point
  assign done = done_r;
  assign root = RW'(r_r) + RW'(s_r > r_r);

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("sqrt restarted while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("sqrt not busy after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r)
    else $error("sqrt done while still busy");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for nearest_neighbor_list_builder_core: drives loads and
// queries on the in_ stream, predicts every neighbor list, checks the out_ stream.
// Depends on nnl_pkg and the core RTL.
module tb;
  import nnl_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0]    idx;
    logic [DIST_OUT_W-1:0] nb_dist;
    logic                  last;
    logic                  bad;
  } nb_rec_t;

  // one row of the directed table; typed rows carry their expected item
  typedef struct packed {
    logic                  act;
    logic [INDEX_W-1:0]    idx;
    logic [IN_COORD_W-1:0] x;
    logic [IN_COORD_W-1:0] y;
    bit                    typed;
    nb_rec_t               exp_rec;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [CITY_COUNT_W-1:0] cfg_wdata;

  nearest_neighbor_list_builder_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state: coordinate copy, register copy, per-query scratch
  logic [IN_COORD_W-1:0] x_mem [4096];
  logic [IN_COORD_W-1:0] y_mem [4096];
  logic [63:0]           dist_mem [4096];
  bit                    taken [4096];
  int unsigned           city_cnt;
  int unsigned           nbr_cnt;

  nb_rec_t   nb_expected [$];
  int        errors;
  int        burst_left;
  bit        hold_req;
  stim_row_t dir_tab [10];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed limit; a full run needs well under 1 ms
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // rounded euclidean distance, bit-by-bit root then round half up
  function automatic logic [63:0] city_dist(input int a, input int b);
    logic [63:0] dx, dy, s, r, t;
    dx = (x_mem[a] > x_mem[b]) ? x_mem[a] - x_mem[b] : x_mem[b] - x_mem[a];
    dy = (y_mem[a] > y_mem[b]) ? y_mem[a] - y_mem[b] : y_mem[b] - y_mem[a];
    s  = dx * dx + dy * dy;
    r  = 0;
    for (int i = 25; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= s) r = t;
    end
    if (s > r * r + r) r = r + 1;
    return r;
  endfunction

  // builds the expected neighbor list of one query
  task automatic predict_neighbors(input logic [INDEX_W-1:0] q);
    int unsigned n, want, best_i;
    logic [63:0] best_d;
    bit found;
    n = (city_cnt > 4096) ? 4096 : city_cnt;
    if (q >= n) begin
      nb_expected.push_back('{q, '0, 1'b1, 1'b1});
      return;
    end
    for (int j = 0; j < n; j++) begin
      dist_mem[j] = city_dist(int'(q), j);
      taken[j] = 1'b0;
    end
    taken[q] = 1'b1;
    want = (nbr_cnt > n - 1) ? n - 1 : nbr_cnt;
    nb_expected.push_back('{q, '0, want == 0, 1'b0});
    for (int r = 1; r <= want; r++) begin
      found = 1'b0;
      best_i = 0;
      best_d = '0;
      // <= lets the higher index win a tie
      for (int j = 0; j < n; j++) begin
        if (!taken[j] && (!found || dist_mem[j] <= best_d)) begin
          found = 1'b1;
          best_i = j;
          best_d = dist_mem[j];
        end
      end
      taken[best_i] = 1'b1;
      nb_expected.push_back('{best_i[INDEX_W-1:0], best_d[DIST_OUT_W-1:0], r == want, 1'b0});
    end
  endtask

  // offers one item in bursts with random gaps; called and returns at negedge
  task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                           input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                           input bit typed, input nb_rec_t exp_rec);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {4'b0, y, x, idx};
    do @(posedge clk); while (!in_tready);
    if (typed) nb_expected.push_back(exp_rec);
    else if (act == ACT_QUERY) predict_neighbors(idx);
    else begin
      x_mem[idx] = x;
      y_mem[idx] = y;
    end
    @(negedge clk);
    burst_left--;
  endtask

  // drain all results, let the block go idle, then write one register
  task automatic write_reg(input logic [0:0] ridx, input logic [CITY_COUNT_W-1:0] val);
    in_tvalid = 1'b0;
    while (nb_expected.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = ridx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (ridx == CFG_CITY_COUNT) city_cnt = 32'(val);
    else nbr_cnt = 32'(val[NEIGHBOR_COUNT_W-1:0]);
  endtask

  // receiver: ready pattern switches among random modes; one long hold-off
  initial begin
    int cyc, mode;
    cyc = 0;
    mode = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = $urandom_range(0, 1);
        default: out_tready = (cyc % 4 != 0);
      endcase
      cyc++;
    end
  end

  // checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    nb_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (nb_expected.size() == 0) begin
        $error("unexpected result item idx=%0d", out_tdata[11:0]);
        errors++;
      end else begin
        e = nb_expected.pop_front();
        if (out_tdata[11:0] !== e.idx) begin
          $error("neighbor_index exp %0d got %0d", e.idx, out_tdata[11:0]);
          errors++;
        end
        if (out_tdata[36:12] !== e.nb_dist) begin
          $error("distance exp %0d got %0d", e.nb_dist, out_tdata[36:12]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_run exp %0b got %0b", e.last, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== e.bad) begin
          $error("bad_query exp %0b got %0b", e.bad, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned n, r;
    errors     = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    city_cnt   = CITY_COUNT_RST;
    nbr_cnt    = NEIGHBOR_COUNT_RST;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ACT_LOAD;
    cfg_we     = 1'b0;
    cfg_index  = CFG_CITY_COUNT;
    cfg_wdata  = '0;

    // corners of the coordinate square: ties from city 0 and max distance
    dir_tab[0] = '{ACT_LOAD,  12'd0,    24'h0,      24'h0,      1'b0, '0};
    dir_tab[1] = '{ACT_LOAD,  12'd1,    24'hFFFFFF, 24'hFFFFFF, 1'b0, '0};
    dir_tab[2] = '{ACT_LOAD,  12'd2,    24'hFFFFFF, 24'h0,      1'b0, '0};
    dir_tab[3] = '{ACT_LOAD,  12'd3,    24'h0,      24'hFFFFFF, 1'b0, '0};
    dir_tab[4] = '{ACT_LOAD,  12'd4095, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0};
    dir_tab[5] = '{ACT_QUERY, 12'd0,    24'h0,      24'h0,      1'b0, '0};
    dir_tab[6] = '{ACT_QUERY, 12'd1,    24'h0,      24'h0,      1'b0, '0};
    dir_tab[7] = '{ACT_QUERY, 12'd3,    24'h0,      24'h0,      1'b0, '0};
    // index not below city count: a single flagged item
    dir_tab[8] = '{ACT_QUERY, 12'd4,    24'h0, 24'h0, 1'b1, '{12'd4,    '0, 1'b1, 1'b1}};
    dir_tab[9] = '{ACT_QUERY, 12'd4095, 24'h0, 24'h0, 1'b1, '{12'd4095, '0, 1'b1, 1'b1}};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: 4 cities, more neighbors asked than exist
    write_reg(CFG_CITY_COUNT, 13'd4);
    write_reg(CFG_NEIGHBOR_COUNT, 13'd63);
    foreach (dir_tab[i])
      send_item(dir_tab[i].act, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y,
                dir_tab[i].typed, dir_tab[i].exp_rec);

    // random phases; all participating cities loaded first
    for (int ph = 0; ph < 3; ph++) begin
      n = (ph == 0) ? 2 : $urandom_range(3, 16);
      write_reg(CFG_CITY_COUNT, CITY_COUNT_W'(n));
      write_reg(CFG_NEIGHBOR_COUNT,
                CITY_COUNT_W'((ph == 0) ? 1 : (ph == 1) ? 63 : $urandom_range(1, 63)));
      for (int c = 0; c < n; c++)
        if (ph == 1) // tight grid, lots of equal distances
          send_item(ACT_LOAD, INDEX_W'(c), IN_COORD_W'($urandom_range(0, 7)),
                    IN_COORD_W'($urandom_range(0, 7)), 1'b0, '0);
        else
          send_item(ACT_LOAD, INDEX_W'(c), IN_COORD_W'($urandom()),
                    IN_COORD_W'($urandom()), 1'b0, '0);
      for (int k = 0; k < 22; k++) begin
        r = $urandom_range(0, 9);
        if (r < 6) send_item(ACT_QUERY, INDEX_W'($urandom_range(0, n - 1)),
                             IN_COORD_W'($urandom()), IN_COORD_W'($urandom()), 1'b0, '0);
        else if (r == 6) send_item(ACT_QUERY, INDEX_W'($urandom_range(n, 4095)),
                                   IN_COORD_W'($urandom()), IN_COORD_W'($urandom()),
                                   1'b0, '0);
        else send_item(ACT_LOAD, INDEX_W'($urandom_range(0, 4095)),
                       IN_COORD_W'($urandom()), IN_COORD_W'($urandom()), 1'b0, '0);
        // long receiver hold-off while input keeps coming: block must back up
        if (ph == 1 && k == 3) hold_req = 1'b1;
      end
    end

    in_tvalid = 1'b0;
    while (nb_expected.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/nnl_pkg.sv
rtl/nnl_sqrt.sv
rtl/nearest_neighbor_list_builder_core.sv
bench/tb.sv
